// File: design/nand_flash_controller_ecc_defines.svh
// ----------------------------------------------------------------------------
// nand flash controller ecc assertion macros
// shared property shapes for the concurrent checks of the register front end
// ----------------------------------------------------------------------------
`ifndef NAND_FLASH_CONTROLLER_ECC_DEFINES_SVH
`define NAND_FLASH_CONTROLLER_ECC_DEFINES_SVH

// same-cycle implication, clocked on clk, off while in reset
`define NFC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nfc ecc same-cycle check failed");

// next-cycle implication, clocked on clk, off while in reset
`define NFC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nfc ecc next-cycle check failed");

`endif

// File: design/nfc_ecc_pkg.sv
// ----------------------------------------------------------------------------
// nfc ecc package
// shared types, register offsets and constants of the nand flash front end
// ----------------------------------------------------------------------------
package nfc_ecc_pkg;

	// ecc block geometry
	localparam int EccBlockBytes = 512;
	localparam int EccCountW     = $clog2(EccBlockBytes + 1);
	localparam int EccRowBits    = $clog2(EccBlockBytes);
	localparam int EccW          = 24;

	// bus register offsets
	localparam logic [4:0] OffConf   = 5'h00;
	localparam logic [4:0] OffCmd    = 5'h04;
	localparam logic [4:0] OffAddr   = 5'h08;
	localparam logic [4:0] OffData   = 5'h0c;
	localparam logic [4:0] OffStatus = 5'h10;
	localparam logic [4:0] OffEcc0   = 5'h14;
	localparam logic [4:0] OffEcc1   = 5'h15;
	localparam logic [4:0] OffEcc2   = 5'h16;

	localparam logic [2:0] SizeByte = 3'd1;
	localparam logic [2:0] SizeWord = 3'd4;

	localparam logic ReqRead  = 1'b0;
	localparam logic ReqWrite = 1'b1;

	localparam logic [15:0] ConfMask = 16'h9f77;
	localparam logic [EccW-1:0] EccClearVal = 24'hffffff;

	// apb configuration space
	localparam int   PaddrW             = 3;
	localparam logic CfgIdxChipAttached = 1'b0;

	typedef enum logic [1:0] {
		CycCmd    = 2'd0,
		CycAddr   = 2'd1,
		CycDataWr = 2'd2,
		CycDataRd = 2'd3
	} chip_cycle_t;

	typedef struct packed {
		logic        req_type;
		logic [4:0]  offset;
		logic [2:0]  access_size;
		logic [31:0] write_data;
		logic        chip_ready;
		logic        chip_ok;
		logic [7:0]  chip_read_byte;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] read_data;
		logic        chip_strobe;
		logic [1:0]  chip_cycle_kind;
		logic [7:0]  chip_write_value;
	} rsp_t;

	typedef struct packed {
		logic [EccW-1:0]      ecc;
		logic [EccCountW-1:0] count;
	} ecc_state_t;

endpackage

// File: design/nfc_ecc_if.sv
// ----------------------------------------------------------------------------
// nfc ecc channel interfaces
// valid/ready request and response channels of the register front end
// ----------------------------------------------------------------------------
interface nfc_ecc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [4:0]  offset;
	logic [2:0]  access_size;
	logic [31:0] write_data;
	logic        chip_ready;
	logic        chip_ok;
	logic [7:0]  chip_read_byte;

	modport source (
		output valid, req_type, offset, access_size, write_data,
		output chip_ready, chip_ok, chip_read_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, offset, access_size, write_data,
		input  chip_ready, chip_ok, chip_read_byte,
		output ready
	);
endinterface

interface nfc_ecc_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [31:0] read_data;
	logic        chip_strobe;
	logic [1:0]  chip_cycle_kind;
	logic [7:0]  chip_write_value;

	modport source (
		output valid, ok, read_data, chip_strobe, chip_cycle_kind, chip_write_value,
		input  ready
	);
	modport sink (
		input  valid, ok, read_data, chip_strobe, chip_cycle_kind, chip_write_value,
		output ready
	);
endinterface

// File: design/nfc_ecc_calc.sv
// ----------------------------------------------------------------------------
// nfc ecc calc
// folds one data byte into the hamming ecc and advances the byte count; once the block is full both are held
// ----------------------------------------------------------------------------
module nfc_ecc_calc (
	input  nfc_ecc_pkg::ecc_state_t cur,
	input  logic [7:0]              data_byte,
	output nfc_ecc_pkg::ecc_state_t nxt
);

	logic [5:0]                      col_par;
	logic                            row_par;
	logic [nfc_ecc_pkg::EccW-1:0]    row_mask;
	logic                            full;

	always_comb begin
		col_par[0] = ^(data_byte & 8'h55);
		col_par[1] = ^(data_byte & 8'haa);
		col_par[2] = ^(data_byte & 8'h33);
		col_par[3] = ^(data_byte & 8'hcc);
		col_par[4] = ^(data_byte & 8'h0f);
		col_par[5] = ^(data_byte & 8'hf0);
		row_par    = ^data_byte;

		// pair i sits at bits 2i and 2i+1, picked by address bit i
		row_mask = '0;
		for (int i = 0; i < nfc_ecc_pkg::EccRowBits; i++) begin
			row_mask[2*i + int'(cur.count[i])] = row_par;
		end

		full = (cur.count >= nfc_ecc_pkg::EccCountW'(nfc_ecc_pkg::EccBlockBytes));

		if (full) begin
			nxt = cur;
		end else begin
			nxt.ecc   = cur.ecc ^ row_mask ^ {col_par, 18'b0};
			nxt.count = cur.count + nfc_ecc_pkg::EccCountW'(1);
		end
	end

endmodule

// File: design/nand_flash_controller_ecc.sv
// ----------------------------------------------------------------------------
// nand flash controller ecc
// path: an access taken goes into the input register stage, then into the result register
// throughput: one access per cycle, stalls only when the result register is held
// reset: arst_n clears config to 0, ecc bytes and count to 0, chip_attached to 1
// ----------------------------------------------------------------------------
`include "nand_flash_controller_ecc_defines.svh"

module nand_flash_controller_ecc (
	input  logic                             clk,
	input  logic                             arst_n,
	nfc_ecc_req_if.sink                      req,
	nfc_ecc_rsp_if.source                    rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [nfc_ecc_pkg::PaddrW-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	// ------------------------------------------------------------------
	// apb configuration: a single chip_attached bit, word index in paddr[2]
	// ------------------------------------------------------------------
	logic chip_attached_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == nfc_ecc_pkg::CfgIdxChipAttached);
	assign prdata = (paddr[2] == nfc_ecc_pkg::CfgIdxChipAttached)
		? {31'b0, chip_attached_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_attached_q <= 1'b1;
		end else if (cfg_wr) begin
			chip_attached_q <= pwdata[0];
		end
	end

	// ------------------------------------------------------------------
	// input register stage
	// ------------------------------------------------------------------
	nfc_ecc_pkg::req_t req_s1;
	logic              valid_s1;
	logic              rsp_valid_q;
	nfc_ecc_pkg::rsp_t rsp_q;
	logic              load_out;

	// result register takes the item when empty or being drained
	assign load_out  = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= '{
				req_type:       req.req_type,
				offset:         req.offset,
				access_size:    req.access_size,
				write_data:     req.write_data,
				chip_ready:     req.chip_ready,
				chip_ok:        req.chip_ok,
				chip_read_byte: req.chip_read_byte
			};
		end
	end

	// ------------------------------------------------------------------
	// architectural state: config register and ecc accumulator
	// ------------------------------------------------------------------
	logic [15:0]             conf_q;
	nfc_ecc_pkg::ecc_state_t ecc_q;
	nfc_ecc_pkg::ecc_state_t ecc_add_nxt;

	// ------------------------------------------------------------------
	// register decode, all from the input stage and current state
	// ------------------------------------------------------------------
	logic                     is_wr;
	logic                     is_byte;
	logic                     size_ok;
	logic [31:0]              val;
	logic                     conf_wr;
	logic                     ecc_clr;
	logic                     ecc_add;
	logic [7:0]               add_byte;
	logic                     res_ok;
	logic [31:0]              res_rd;
	logic                     res_strobe;
	nfc_ecc_pkg::chip_cycle_t res_kind;
	logic [7:0]               res_wv;

	always_comb begin
		is_wr    = (req_s1.req_type == nfc_ecc_pkg::ReqWrite);
		is_byte  = (req_s1.access_size == nfc_ecc_pkg::SizeByte);
		size_ok  = is_byte || (req_s1.access_size == nfc_ecc_pkg::SizeWord);
		val      = is_byte ? {24'b0, req_s1.write_data[7:0]} : req_s1.write_data;
		add_byte = is_wr ? val[7:0] : req_s1.chip_read_byte;

		conf_wr    = 1'b0;
		ecc_clr    = 1'b0;
		ecc_add    = 1'b0;
		res_ok     = 1'b0;
		res_rd     = 32'b0;
		res_strobe = 1'b0;
		res_kind   = nfc_ecc_pkg::CycCmd;
		res_wv     = 8'b0;

		if (size_ok) begin
			unique case (req_s1.offset) inside
				nfc_ecc_pkg::OffConf: begin
					if (is_wr) begin
						// byte writes to config are refused
						if (!is_byte) begin
							conf_wr = 1'b1;
							res_ok  = 1'b1;
						end
					end else begin
						res_rd = {16'b0, conf_q};
						res_ok = 1'b1;
					end
				end
				nfc_ecc_pkg::OffCmd, nfc_ecc_pkg::OffAddr: begin
					// command and address writes restart the ecc block even on failure
					if (is_wr) begin
						ecc_clr = 1'b1;
						if (chip_attached_q) begin
							res_strobe = 1'b1;
							res_kind   = (req_s1.offset == nfc_ecc_pkg::OffCmd)
								? nfc_ecc_pkg::CycCmd : nfc_ecc_pkg::CycAddr;
							res_wv     = val[7:0];
							res_ok     = req_s1.chip_ok;
						end
					end
				end
				nfc_ecc_pkg::OffData: begin
					if (chip_attached_q) begin
						res_strobe = 1'b1;
						if (is_wr) begin
							res_kind = nfc_ecc_pkg::CycDataWr;
							res_wv   = val[7:0];
						end else begin
							res_kind = nfc_ecc_pkg::CycDataRd;
						end
						// only a transfer the chip took goes into the ecc
						if (req_s1.chip_ok) begin
							res_ok  = 1'b1;
							ecc_add = 1'b1;
							res_rd  = {24'b0, req_s1.chip_read_byte};
						end
					end
				end
				nfc_ecc_pkg::OffStatus: begin
					res_ok = 1'b1;
					res_rd = {31'b0, chip_attached_q && req_s1.chip_ready};
				end
				nfc_ecc_pkg::OffEcc0: begin
					res_ok = 1'b1;
					res_rd = {8'b0, ecc_q.ecc};
				end
				nfc_ecc_pkg::OffEcc1: begin
					if (!is_wr && is_byte) begin
						res_ok = 1'b1;
						res_rd = {24'b0, ecc_q.ecc[15:8]};
					end
				end
				nfc_ecc_pkg::OffEcc2: begin
					if (!is_wr && is_byte) begin
						res_ok = 1'b1;
						res_rd = {24'b0, ecc_q.ecc[23:16]};
					end
				end
				default: begin
					res_ok = 1'b0;
				end
			endcase

			// writes and errors return no data, byte reads keep the low byte
			if (!res_ok || is_wr) begin
				res_rd = 32'b0;
			end else if (is_byte) begin
				res_rd = {24'b0, res_rd[7:0]};
			end
		end
	end

	nfc_ecc_calc u_calc (
		.cur       (ecc_q),
		.data_byte (add_byte),
		.nxt       (ecc_add_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q <= 16'b0;
			ecc_q  <= '0;
		end else if (load_out) begin
			if (conf_wr) begin
				conf_q <= val[15:0] & nfc_ecc_pkg::ConfMask;
			end
			if (ecc_clr) begin
				ecc_q.ecc   <= nfc_ecc_pkg::EccClearVal;
				ecc_q.count <= '0;
			end else if (ecc_add) begin
				ecc_q <= ecc_add_nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= '{
				ok:               res_ok,
				read_data:        res_rd,
				chip_strobe:      res_strobe,
				chip_cycle_kind:  res_kind,
				chip_write_value: res_wv
			};
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.ok               = rsp_q.ok;
	assign rsp.read_data        = rsp_q.read_data;
	assign rsp.chip_strobe      = rsp_q.chip_strobe;
	assign rsp.chip_cycle_kind  = rsp_q.chip_cycle_kind;
	assign rsp.chip_write_value = rsp_q.chip_write_value;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	// byte count never runs past one ecc block
	`NFC_ASSERT_IMP(a_count_bound, 1'b1,
		ecc_q.count <= nfc_ecc_pkg::EccCountW'(nfc_ecc_pkg::EccBlockBytes))
	// a command or address write leaves a fresh block behind
	`NFC_ASSERT_NXT(a_clear_count, load_out && ecc_clr, ecc_q.count == '0)
	// a failed access never carries read data
	`NFC_ASSERT_IMP(a_err_no_data, rsp_valid_q && !rsp_q.ok, rsp_q.read_data == 32'b0)
	// without a strobe the flash-side fields stay quiet
	`NFC_ASSERT_IMP(a_idle_chip, rsp_valid_q && !rsp_q.chip_strobe,
		rsp_q.chip_cycle_kind == nfc_ecc_pkg::CycCmd && rsp_q.chip_write_value == 8'b0)

endmodule
